### src/assert_macros.svh
// Assertion macros used by the serial command frame parser top level.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCF_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SCF_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/scf_pkg.sv
// Types and constants for the serial command frame parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package scf_pkg;

  localparam logic [7:0] HDR0        = 8'h00;
  localparam logic [7:0] CMD_RUN     = 8'h52;
  localparam logic [7:0] CMD_LOAD    = 8'h53;
  localparam logic [7:0] RUN_TAIL    = 8'h55;
  localparam logic [7:0] LOAD_TAIL   = 8'h54;
  localparam logic [7:0] SHORT_COUNT = 8'h01;
  localparam logic [7:0] READY_MARK  = 8'h02;
  localparam logic [6:0] LIMIT_RESET = 7'd30;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_HDR   = 7'b0000010,
    PH_RUN   = 7'b0000100,
    PH_LOAD  = 7'b0001000,
    PH_COUNT = 7'b0010000,
    PH_FIRST = 7'b0100000,
    PH_DATA  = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       run_mode;
    logic [6:0] count_half;
    logic [7:0] remaining;
    logic [7:0] running_sum;
    logic       led_level;
    logic       loaded_level;
  } pstate_t;

  typedef struct packed {
    logic       running;
    logic       download_ok;
    logic       card_loaded;
    logic [6:0] card_count;
    logic       clear_outputs;
    logic       play_start;
    logic       ready_pulse;
    logic       run_start;
  } result_t;

endpackage

### src/scf_step.sv
// Next-state and result logic for one received byte.
// Depends on scf_pkg for the state and result types.
`timescale 1ns / 1ps

module scf_step (
  input  scf_pkg::pstate_t cur,
  input  logic [7:0]       rx_byte,
  input  logic [6:0]       count_limit,
  output scf_pkg::pstate_t nxt,
  output scf_pkg::result_t res
);

  logic       clr;
  logic       play;
  logic       rdy;
  logic       rstart;
  logic [6:0] half;

  assign half = rx_byte[7:1];

  always_comb begin
    nxt    = cur;
    clr    = 1'b0;
    play   = 1'b0;
    rdy    = 1'b0;
    rstart = 1'b0;
    case (cur.phase)
      scf_pkg::PH_IDLE: begin
        if (rx_byte == scf_pkg::HDR0) begin
          nxt.phase = scf_pkg::PH_HDR;
        end else begin
          nxt.phase = scf_pkg::PH_IDLE;
          nxt.run_mode = 1'b0;
          nxt.led_level = 1'b0;
          nxt.loaded_level = 1'b0;
          clr = 1'b1;
        end
      end
      scf_pkg::PH_HDR: begin
        if (rx_byte == scf_pkg::CMD_LOAD) begin
          nxt.phase = scf_pkg::PH_LOAD;
        end else if (rx_byte == scf_pkg::CMD_RUN) begin
          nxt.phase = scf_pkg::PH_RUN;
        end else begin
          nxt.phase = scf_pkg::PH_IDLE;
          nxt.run_mode = 1'b0;
          nxt.led_level = 1'b0;
          nxt.loaded_level = 1'b0;
          clr = 1'b1;
        end
      end
      scf_pkg::PH_RUN: begin
        nxt.phase = scf_pkg::PH_IDLE;
        if (rx_byte == scf_pkg::RUN_TAIL) begin
          nxt.run_mode = ~cur.run_mode;
          rstart = ~cur.run_mode;
          play = ~cur.run_mode;
          nxt.led_level = 1'b0;
        end else begin
          nxt.run_mode = 1'b0;
          nxt.led_level = 1'b0;
          nxt.loaded_level = 1'b0;
          clr = 1'b1;
        end
      end
      scf_pkg::PH_LOAD: begin
        nxt.run_mode = 1'b0;
        nxt.led_level = 1'b0;
        if (rx_byte == scf_pkg::LOAD_TAIL) begin
          nxt.phase = scf_pkg::PH_COUNT;
        end else begin
          nxt.phase = scf_pkg::PH_IDLE;
          nxt.loaded_level = 1'b0;
          clr = 1'b1;
        end
      end
      scf_pkg::PH_COUNT: begin
        nxt.run_mode = 1'b0;
        nxt.led_level = 1'b0;
        nxt.count_half = half;
        nxt.remaining = {half, 1'b0} - 8'd1;
        nxt.running_sum = rx_byte;
        if ((half != 7'd0) && (half < count_limit)) begin
          nxt.phase = scf_pkg::PH_FIRST;
        end else if (rx_byte == scf_pkg::SHORT_COUNT) begin
          nxt.phase = scf_pkg::PH_FIRST;
          clr = 1'b1;
        end else begin
          nxt.phase = scf_pkg::PH_IDLE;
          nxt.loaded_level = 1'b0;
          clr = 1'b1;
        end
      end
      scf_pkg::PH_FIRST: begin
        nxt.run_mode = 1'b0;
        nxt.led_level = 1'b0;
        if (cur.count_half != 7'd0) begin
          nxt.running_sum = cur.running_sum + rx_byte;
        end
        clr = 1'b1;
        nxt.phase = scf_pkg::PH_DATA;
      end
      scf_pkg::PH_DATA: begin
        nxt.run_mode = 1'b0;
        rdy = (cur.remaining == scf_pkg::READY_MARK);
        if (cur.remaining != 8'd0) begin
          nxt.remaining = cur.remaining - 8'd1;
          if (cur.count_half != 7'd0) begin
            nxt.running_sum = cur.running_sum + rx_byte;
          end
        end else begin
          nxt.phase = scf_pkg::PH_IDLE;
          if (rx_byte == cur.running_sum) begin
            nxt.loaded_level = 1'b1;
            nxt.led_level = 1'b1;
            play = 1'b1;
            clr = 1'b1;
          end else begin
            nxt.led_level = 1'b0;
          end
        end
      end
      default: begin
        nxt.phase = scf_pkg::PH_IDLE;
        nxt.run_mode = 1'b0;
        nxt.led_level = 1'b0;
        nxt.loaded_level = 1'b0;
        clr = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.running       = nxt.run_mode;
    res.download_ok   = nxt.led_level;
    res.card_loaded   = nxt.loaded_level;
    res.card_count    = nxt.count_half;
    res.clear_outputs = clr;
    res.play_start    = play;
    res.ready_pulse   = rdy;
    res.run_start     = rstart;
  end

endmodule

### src/scf_out_q.sv
// Two-entry result queue that separates the parser from the output channel.
// Depends on scf_pkg for the result type.
`timescale 1ns / 1ps

module scf_out_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  scf_pkg::result_t wr_data,
  output logic             not_full,
  output logic             rd_valid,
  input  logic             rd_en,
  output scf_pkg::result_t rd_data
);

  scf_pkg::result_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign not_full = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/serial_command_frame_parser.sv
// Top level of the serial command frame parser: state registers and queue.
// Depends on scf_pkg, scf_step, scf_out_q and assert_macros.svh.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    rx_byte
//   out      output     out_valid/out_ready  running .. run_start
//   cfg      input      cfg_we               cfg_data (count_limit)
//
// One byte is taken per cycle while in_ready is high; each byte's result is
// registered in the two-entry result queue before it is offered on out.
// Reset is synchronous and needs no clearing pass.
// in_ready drops only while both queue entries wait on out_ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_command_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       running,
  output logic       download_ok,
  output logic       card_loaded,
  output logic [6:0] card_count,
  output logic       clear_outputs,
  output logic       play_start,
  output logic       ready_pulse,
  output logic       run_start,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  scf_pkg::pstate_t state;
  scf_pkg::pstate_t state_next;
  scf_pkg::result_t step_res;
  scf_pkg::result_t q_res;
  logic [6:0]       count_limit;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  scf_step u_step (
    .cur         (state),
    .rx_byte     (rx_byte),
    .count_limit (count_limit),
    .nxt         (state_next),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= scf_pkg::PH_IDLE;
      state.run_mode     <= 1'b0;
      state.count_half   <= 7'd0;
      state.remaining    <= 8'd0;
      state.running_sum  <= 8'd0;
      state.led_level    <= 1'b0;
      state.loaded_level <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= scf_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      count_limit <= cfg_data;
    end
  end

  scf_out_q u_q (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_fire),
    .wr_data  (step_res),
    .not_full (in_ready),
    .rd_valid (out_valid),
    .rd_en    (out_valid && out_ready),
    .rd_data  (q_res)
  );

  assign running       = q_res.running;
  assign download_ok   = q_res.download_ok;
  assign card_loaded   = q_res.card_loaded;
  assign card_count    = q_res.card_count;
  assign clear_outputs = q_res.clear_outputs;
  assign play_start    = q_res.play_start;
  assign ready_pulse   = q_res.ready_pulse;
  assign run_start     = q_res.run_start;

  `SCF_ASSERT_IMP(a_play_level, clk, rst, in_fire && step_res.play_start,
                  step_res.running || step_res.download_ok)
  `SCF_ASSERT_IMP(a_ready_quiet, clk, rst, in_fire && step_res.ready_pulse,
                  !step_res.clear_outputs && !step_res.play_start)
  `SCF_ASSERT_NXT(a_first_to_data, clk, rst,
                  in_fire && (state.phase == scf_pkg::PH_FIRST),
                  state.phase == scf_pkg::PH_DATA)
  `SCF_ASSERT_NXT(a_count_hold, clk, rst,
                  !(in_fire && (state.phase == scf_pkg::PH_COUNT)),
                  $stable(state.count_half))

endmodule

### tb/tb_serial_command_frame_parser.sv
// Self-checking testbench for the serial command frame parser.
// Depends on scf_pkg and serial_command_frame_parser; the scoreboard class
// predicts the flags for every byte transfer and checks each result transfer.
`timescale 1ns / 1ps

module tb_serial_command_frame_parser;

  class frame_scoreboard;
    scf_pkg::phase_t  frame_phase;
    logic             run_mode;
    logic [6:0]       count_half;
    logic [7:0]       remaining;
    logic [7:0]       check_sum;
    logic             led_level;
    logic             loaded_level;
    logic [6:0]       count_limit;
    scf_pkg::result_t expected_flags[$];
    int               errors;

    function new();
      frame_phase  = scf_pkg::PH_IDLE;
      run_mode     = 1'b0;
      count_half   = '0;
      remaining    = '0;
      check_sum    = '0;
      led_level    = 1'b0;
      loaded_level = 1'b0;
      count_limit  = scf_pkg::LIMIT_RESET;
      errors       = 0;
    endfunction

    function void set_limit(logic [6:0] value);
      count_limit = value;
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction

    function logic abandon_frame();
      frame_phase  = scf_pkg::PH_IDLE;
      run_mode     = 1'b0;
      led_level    = 1'b0;
      loaded_level = 1'b0;
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] b);
      scf_pkg::result_t r;
      logic clr, play, rdy, homing;
      clr = 1'b0;
      play = 1'b0;
      rdy = 1'b0;
      homing = 1'b0;
      case (frame_phase)
        scf_pkg::PH_IDLE: begin
          if (b == scf_pkg::HDR0) frame_phase = scf_pkg::PH_HDR;
          else clr = abandon_frame();
        end
        scf_pkg::PH_HDR: begin
          if (b == scf_pkg::CMD_LOAD) frame_phase = scf_pkg::PH_LOAD;
          else if (b == scf_pkg::CMD_RUN) frame_phase = scf_pkg::PH_RUN;
          else clr = abandon_frame();
        end
        scf_pkg::PH_RUN: begin
          if (b == scf_pkg::RUN_TAIL) begin
            if (!run_mode) begin
              run_mode = 1'b1;
              homing = 1'b1;
              play = 1'b1;
            end else begin
              run_mode = 1'b0;
            end
            led_level = 1'b0;
            frame_phase = scf_pkg::PH_IDLE;
          end else begin
            clr = abandon_frame();
          end
        end
        scf_pkg::PH_LOAD: begin
          run_mode = 1'b0;
          led_level = 1'b0;
          if (b == scf_pkg::LOAD_TAIL) frame_phase = scf_pkg::PH_COUNT;
          else clr = abandon_frame();
        end
        scf_pkg::PH_COUNT: begin
          run_mode = 1'b0;
          led_level = 1'b0;
          count_half = b[7:1];
          remaining = {count_half, 1'b0} - 8'd1;
          check_sum = b;
          if (count_half != 0 && count_half < count_limit) begin
            frame_phase = scf_pkg::PH_FIRST;
          end else if (b == scf_pkg::SHORT_COUNT) begin
            frame_phase = scf_pkg::PH_FIRST;
            clr = 1'b1;
          end else begin
            clr = abandon_frame();
          end
        end
        scf_pkg::PH_FIRST: begin
          run_mode = 1'b0;
          led_level = 1'b0;
          if (count_half != 0) check_sum = check_sum + b;
          clr = 1'b1;
          frame_phase = scf_pkg::PH_DATA;
        end
        scf_pkg::PH_DATA: begin
          run_mode = 1'b0;
          if (remaining == scf_pkg::READY_MARK) rdy = 1'b1;
          if (remaining != 0) begin
            remaining = remaining - 8'd1;
            if (count_half != 0) check_sum = check_sum + b;
          end else begin
            if (b == check_sum) begin
              loaded_level = 1'b1;
              led_level = 1'b1;
              play = 1'b1;
              clr = 1'b1;
            end else begin
              led_level = 1'b0;
            end
            frame_phase = scf_pkg::PH_IDLE;
          end
        end
        default: clr = abandon_frame();
      endcase
      r.running       = run_mode;
      r.download_ok   = led_level;
      r.card_loaded   = loaded_level;
      r.card_count    = count_half;
      r.clear_outputs = clr;
      r.play_start    = play;
      r.ready_pulse   = rdy;
      r.run_start     = homing;
      expected_flags.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_flags(scf_pkg::result_t got);
      scf_pkg::result_t want;
      if (expected_flags.size() == 0) begin
        $display("%0t: result transfer with nothing expected, got %p", $time, got);
        errors++;
        return;
      end
      want = expected_flags.pop_front();
      compare_field("running", int'(want.running), int'(got.running));
      compare_field("download_ok", int'(want.download_ok), int'(got.download_ok));
      compare_field("card_loaded", int'(want.card_loaded), int'(got.card_loaded));
      compare_field("card_count", int'(want.card_count), int'(got.card_count));
      compare_field("clear_outputs", int'(want.clear_outputs),
                    int'(got.clear_outputs));
      compare_field("play_start", int'(want.play_start), int'(got.play_start));
      compare_field("ready_pulse", int'(want.ready_pulse), int'(got.ready_pulse));
      compare_field("run_start", int'(want.run_start), int'(got.run_start));
    endfunction
  endclass

  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY, PACE_BURSTY} rx_pace_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       running;
  logic       download_ok;
  logic       card_loaded;
  logic [6:0] card_count;
  logic       clear_outputs;
  logic       play_start;
  logic       ready_pulse;
  logic       run_start;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = 7'd0;

  frame_scoreboard sb = new();
  int       burst_left = 0;
  int       sent_count = 0;
  int       cur_limit = int'(scf_pkg::LIMIT_RESET);
  rx_pace_t pace = PACE_FULL;
  int       pace_left = 0;

  serial_command_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .running(running),
    .download_ok(download_ok),
    .card_loaded(card_loaded),
    .card_count(card_count),
    .clear_outputs(clear_outputs),
    .play_start(play_start),
    .ready_pulse(ready_pulse),
    .run_start(run_start),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    scf_pkg::result_t seen;
    if (!rst) begin
      seen.running       = running;
      seen.download_ok   = download_ok;
      seen.card_loaded   = card_loaded;
      seen.card_count    = card_count;
      seen.clear_outputs = clear_outputs;
      seen.play_start    = play_start;
      seen.ready_pulse   = ready_pulse;
      seen.run_start     = run_start;
      if (out_valid && out_ready) sb.check_flags(seen);
      if (in_valid && in_ready) sb.note_byte(rx_byte);
    end
  end

  always @(negedge clk) begin
    if (pace_left == 0) begin
      pace = rx_pace_t'($urandom_range(0, 3));
      pace_left = $urandom_range(10, 60);
    end
    pace_left--;
    case (pace)
      PACE_FULL:  out_ready <= 1'b1;
      PACE_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      PACE_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= ((pace_left % 8) < 5);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_count_limit(input logic [6:0] value);
    drain_results();
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
    cur_limit = int'(value);
  endtask

  task automatic settle_idle();
    drain_results();
    while (sb.frame_phase != scf_pkg::PH_IDLE) begin
      send_byte(8'($urandom_range(0, 255)));
      drain_results();
    end
  endtask

  task automatic load_frame(input logic [7:0] n, input bit good);
    logic [7:0] sum;
    logic [7:0] p;
    int len;
    send_byte(scf_pkg::HDR0);
    send_byte(scf_pkg::CMD_LOAD);
    send_byte(scf_pkg::LOAD_TAIL);
    send_byte(n);
    sum = n;
    len = (n == scf_pkg::SHORT_COUNT) ? 256 : 2 * n[7:1];
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom_range(0, 255));
      if (n != scf_pkg::SHORT_COUNT) sum = sum + p;
      send_byte(p);
    end
    if (!good) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic random_frame();
    int pick;
    int h;
    int hi;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 99) < 2) begin
        load_frame(scf_pkg::SHORT_COUNT, $urandom_range(0, 3) != 0);
      end else if (cur_limit > 1) begin
        hi = (cur_limit - 1 < 6) ? cur_limit - 1 : 6;
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cur_limit - 1)
                                        : $urandom_range(1, hi);
        load_frame({h[6:0], 1'($urandom_range(0, 1))}, $urandom_range(0, 9) != 0);
      end else begin
        load_frame({7'($urandom_range(1, 127)), 1'($urandom_range(0, 1))}, 1'b1);
      end
    end else if (pick < 70) begin
      send_byte(scf_pkg::HDR0);
      send_byte(scf_pkg::CMD_RUN);
      send_byte(scf_pkg::RUN_TAIL);
    end else if (pick < 80) begin
      send_byte(scf_pkg::HDR0);
      send_byte(scf_pkg::CMD_LOAD);
      send_byte(scf_pkg::LOAD_TAIL);
      if ($urandom_range(0, 3) == 0) begin
        send_byte(8'h00);
      end else begin
        h = $urandom_range(cur_limit, 127);
        send_byte({h[6:0], 1'($urandom_range(0, 1))});
      end
    end else if (pick < 90) begin
      send_byte(scf_pkg::HDR0);
      case ($urandom_range(0, 2))
        0: send_byte(scf_pkg::CMD_RUN);
        1: begin
          send_byte(scf_pkg::CMD_LOAD);
        end
        default: ;
      endcase
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = sent_count;
    while (sent_count - start < budget) begin
      if ($urandom_range(0, 99) == 0) drain_results();
      random_frame();
    end
  endtask

  initial begin
    logic [7:0] opening[$];
    opening = '{scf_pkg::HDR0, scf_pkg::CMD_RUN, scf_pkg::RUN_TAIL,
                scf_pkg::HDR0, scf_pkg::CMD_RUN, scf_pkg::RUN_TAIL, 8'hFF,
                scf_pkg::HDR0, scf_pkg::CMD_LOAD, scf_pkg::LOAD_TAIL,
                8'h04, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h02,
                scf_pkg::HDR0, scf_pkg::CMD_LOAD, scf_pkg::LOAD_TAIL,
                8'h03, 8'h80, 8'h7F, 8'h55,
                scf_pkg::HDR0, scf_pkg::CMD_LOAD, scf_pkg::LOAD_TAIL, 8'h3C};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (opening[i]) send_byte(opening[i]);
    run_random(220);
    write_count_limit(7'd127);
    run_random(180);
    write_count_limit(7'd1);
    settle_idle();
    load_frame(scf_pkg::SHORT_COUNT, 1'b1);
    run_random(80);
    write_count_limit(7'($urandom_range(2, 126)));
    run_random(160);
    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
